FILE: rtl/core/erttm_pkg.sv
package erttm_pkg;

  // Event kinds carried in the func field
  typedef enum logic [1:0] {
    FUNC_CAPTURE  = 2'd0,
    FUNC_OVERFLOW = 2'd1,
    FUNC_BUTTON   = 2'd2,
    FUNC_SAMPLE   = 2'd3
  } erttm_func_t;

  typedef struct packed {
    erttm_func_t  func;
    logic [15:0]  capture_time;
    logic [9:0]   sample;
  } erttm_in_t;

  typedef struct packed {
    logic [9:0] range_cm;
    logic [7:0] tone_top;
    logic [7:0] duty_compare;
    logic       discrete_mode;
    logic       range_updated;
  } erttm_out_t;

  // Pulse length clipped to the last value that still maps below 1024 cm
  localparam int          PERIOD_W   = 17;
  localparam logic [16:0] PERIOD_MAX = 17'd118783;

  // floor(p/116) == (p * RANGE_RECIP) >> RANGE_SHIFT for every p <= PERIOD_MAX
  localparam int          RECIP_W     = 18;
  localparam logic [17:0] RANGE_RECIP = 18'd144632;
  localparam int          RANGE_SHIFT = 24;

  // Word passed from the capture stage to the mapping stage
  typedef struct packed {
    erttm_func_t          func;
    logic [9:0]           sample;
    logic                 closed;
    logic [PERIOD_W-1:0]  period;
  } erttm_pulse_t;

  localparam logic [7:0] TOP_RESET  = 8'd59;
  localparam logic [7:0] TOP_OFFSET = 8'd57;
  localparam logic [7:0] TOP_MIN    = 8'd57;

  localparam int         BAND_COUNT = 8;
  localparam logic [9:0] BAND_LOW   = 10'd2;
  localparam logic [9:0] BAND_UPPER [BAND_COUNT] =
    '{10'd33, 10'd64, 10'd95, 10'd126, 10'd157, 10'd188, 10'd219, 10'd249};
  localparam logic [7:0] BAND_TOP [BAND_COUNT] =
    '{8'd118, 8'd106, 8'd94, 8'd88, 8'd78, 8'd70, 8'd62, 8'd58};

  // Banded tone top; distances outside every band keep the old value
  function automatic logic [7:0] band_top(input logic [9:0] d, input logic [7:0] hold);
    logic [7:0] r;
    logic       hit;
    r   = hold;
    hit = 1'b0;
    if (d > BAND_LOW) begin
      for (int i = 0; i < BAND_COUNT; i++) begin
        if (!hit && d <= BAND_UPPER[i]) begin
          r   = BAND_TOP[i];
          hit = 1'b1;
        end
      end
    end
    return r;
  endfunction

  // Duty numerator over 20; zero means hold (includes the 510..585 gap)
  function automatic logic [3:0] duty_factor(input logic [9:0] s);
    logic [3:0] k;
    priority if (s == 10'd0)   k = 4'd0;
    else if (s <= 10'd213)     k = 4'd1;
    else if (s <= 10'd287)     k = 4'd2;
    else if (s <= 10'd361)     k = 4'd4;
    else if (s <= 10'd435)     k = 4'd5;
    else if (s <= 10'd509)     k = 4'd6;
    else if (s <= 10'd585)     k = 4'd0;
    else if (s <= 10'd658)     k = 4'd7;
    else if (s <= 10'd733)     k = 4'd8;
    else if (s <= 10'd808)     k = 4'd9;
    else if (s <= 10'd882)     k = 4'd10;
    else                       k = 4'd0;
    return k;
  endfunction

endpackage

FILE: rtl/core/erttm_capture.sv
module erttm_capture (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  erttm_pkg::erttm_in_t    in_data,
  output logic                    s1_valid,
  output erttm_pkg::erttm_pulse_t s1_data,
  input  logic                    s1_take
);
  import erttm_pkg::*;

  logic                 edge_phase_r, edge_phase_nxt;
  logic [15:0]          start_r, start_nxt;
  logic [7:0]           ovf_r, ovf_nxt;
  logic                 s1_v_r, s1_v_nxt;
  erttm_pulse_t         pulse_r, pulse_nxt;
  logic                 load;
  logic [24:0]          diff;
  logic [PERIOD_W-1:0]  period;

  assign in_stall = s1_v_r && !s1_take;
  assign load     = in_valid && !in_stall;
  assign s1_valid = s1_v_r;
  assign s1_data  = pulse_r;

  // Ticks since the opening edge; a borrow means a negative pulse
  assign diff = {1'b0, ovf_r, in_data.capture_time} - {9'd0, start_r};

  always_comb begin
    if (diff[24]) begin
      period = '0;
    end else if (diff[23:0] > 24'(PERIOD_MAX)) begin
      period = PERIOD_MAX;
    end else begin
      period = diff[PERIOD_W-1:0];
    end
  end

  always_comb begin
    edge_phase_nxt   = edge_phase_r;
    start_nxt        = start_r;
    ovf_nxt          = ovf_r;
    pulse_nxt        = pulse_r;
    s1_v_nxt         = s1_v_r;
    if (s1_take) begin
      s1_v_nxt = 1'b0;
    end
    if (load) begin
      s1_v_nxt         = 1'b1;
      pulse_nxt.func   = in_data.func;
      pulse_nxt.sample = in_data.sample;
      pulse_nxt.period = period;
      pulse_nxt.closed = 1'b0;
      unique case (in_data.func)
        FUNC_CAPTURE: begin
          if (!edge_phase_r) begin
            start_nxt      = in_data.capture_time;
            edge_phase_nxt = 1'b1;
          end else begin
            edge_phase_nxt   = 1'b0;
            ovf_nxt          = '0;
            pulse_nxt.closed = 1'b1;
          end
        end
        FUNC_OVERFLOW: ovf_nxt = ovf_r + 8'd1;
        FUNC_BUTTON:   ;
        FUNC_SAMPLE:   ;
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_phase_r <= 1'b0;
      start_r      <= '0;
      ovf_r        <= '0;
      s1_v_r       <= 1'b0;
    end else begin
      edge_phase_r <= edge_phase_nxt;
      start_r      <= start_nxt;
      ovf_r        <= ovf_nxt;
      s1_v_r       <= s1_v_nxt;
    end
    pulse_r <= pulse_nxt;
  end

`ifndef SYNTHESIS
  a_close_clears_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    load && in_data.func == FUNC_CAPTURE && edge_phase_r |=>
      ovf_r == 8'd0 && !edge_phase_r && pulse_r.closed)
    else $error("closing edge did not clear overflow count");

  a_period_clipped: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |-> pulse_r.period <= PERIOD_MAX)
    else $error("pulse period beyond clip value");
`endif

endmodule

FILE: rtl/core/erttm_map.sv
module erttm_map (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    s1_valid,
  input  erttm_pkg::erttm_pulse_t s1_data,
  output logic                    s1_take,
  output logic                    out_valid,
  input  logic                    out_stall,
  output erttm_pkg::erttm_out_t   out_data
);
  import erttm_pkg::*;

  logic                          press_r, press_nxt;
  logic                          mode_r, mode_nxt;
  logic [9:0]                    dist_r, dist_nxt;
  logic [7:0]                    top_r, top_nxt;
  logic [7:0]                    cmp_r, cmp_nxt;
  logic                          out_v_r, out_v_nxt;
  erttm_out_t                    out_r, out_nxt;
  logic                          adv;
  logic [PERIOD_W+RECIP_W-1:0]   prod;
  logic [9:0]                    dist_new;
  logic [17:0]                   d249;
  logic [8:0]                    tone_sum;
  logic [7:0]                    tone_cont;
  logic [3:0]                    k;
  logic [11:0]                   top_k;
  logic [9:0]                    quarter;
  logic [17:0]                   q205;
  logic [7:0]                    duty_new;

  assign adv       = s1_valid && (!out_v_r || !out_stall);
  assign s1_take   = adv;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // Distance: reciprocal multiply, exact over the clipped period range
  assign prod     = (PERIOD_W+RECIP_W)'(s1_data.period) * (PERIOD_W+RECIP_W)'(RANGE_RECIP);
  assign dist_new = prod[RANGE_SHIFT +: 10];

  // Continuous tone: d*249 = d*256 - d*4 - d*2 - d
  assign d249      = {dist_new, 8'd0} - {6'd0, dist_new, 2'd0}
                   - {7'd0, dist_new, 1'd0} - {8'd0, dist_new};
  assign tone_sum  = {1'b0, d249[17:10]} + {1'b0, TOP_OFFSET};
  assign tone_cont = tone_sum[8] ? 8'hFF : tone_sum[7:0];

  // Duty: floor(top*k/20) = floor(floor(top*k/4)*205 >> 10)
  assign k        = duty_factor(s1_data.sample);
  assign top_k    = 12'(top_r) * 12'(k);
  assign quarter  = top_k[11:2];
  assign q205     = {1'b0, quarter, 7'd0} + {2'd0, quarter, 6'd0} + {5'd0, quarter, 3'd0}
                  + {6'd0, quarter, 2'd0} + {8'd0, quarter};
  assign duty_new = q205[17:10];

  always_comb begin
    press_nxt = press_r;
    mode_nxt  = mode_r;
    dist_nxt  = dist_r;
    top_nxt   = top_r;
    cmp_nxt   = cmp_r;
    out_nxt   = out_r;
    out_v_nxt = out_v_r;
    if (!out_stall) begin
      out_v_nxt = 1'b0;
    end
    if (adv) begin
      out_v_nxt = 1'b1;
      unique case (s1_data.func)
        FUNC_CAPTURE: begin
          if (s1_data.closed) begin
            dist_nxt = dist_new;
            top_nxt  = mode_r ? band_top(dist_new, top_r) : tone_cont;
          end
        end
        FUNC_OVERFLOW: ;
        FUNC_BUTTON: begin
          press_nxt = !press_r;
          if (press_r) begin
            mode_nxt = !mode_r;
          end
        end
        FUNC_SAMPLE: begin
          if (k != 4'd0) begin
            cmp_nxt = duty_new;
          end
        end
        default: ;
      endcase
      out_nxt.range_cm      = dist_nxt;
      out_nxt.tone_top      = top_nxt;
      out_nxt.duty_compare  = cmp_nxt;
      out_nxt.discrete_mode = mode_nxt;
      out_nxt.range_updated = s1_data.closed;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_r <= 1'b0;
      mode_r  <= 1'b0;
      dist_r  <= '0;
      top_r   <= TOP_RESET;
      cmp_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      press_r <= press_nxt;
      mode_r  <= mode_nxt;
      dist_r  <= dist_nxt;
      top_r   <= top_nxt;
      cmp_r   <= cmp_nxt;
      out_v_r <= out_v_nxt;
    end
    out_r <= out_nxt;
  end

`ifndef SYNTHESIS
  a_top_floor: assert property (@(posedge clk) disable iff (!rst_n)
    top_r >= TOP_MIN)
    else $error("tone top below lowest mapped value");

  a_dist_only_on_close: assert property (@(posedge clk) disable iff (!rst_n)
    adv && !s1_data.closed |=> $stable(dist_r))
    else $error("distance changed without a closed pulse");
`endif

endmodule

FILE: rtl/core/echo_range_to_tone_mapper.sv
// A word accepted at the input is registered in the capture stage, then in the
// mapping stage's output register, where out_valid rises. Throughput: one word per
// cycle while out_stall is low; capture stage, then mapping stage with output register.
// Reset (rst_n low, synchronous): both stages empty, edge phase, start time,
// overflow count, press count, mode and distance cleared, tone top 59, duty 0.
module echo_range_to_tone_mapper (
  input  logic                  clk,
  input  logic                  rst_n,
  // event words
  input  logic                  in_valid,
  output logic                  in_stall,
  input  erttm_pkg::erttm_in_t  in_data,
  // result words, one per event
  output logic                  out_valid,
  input  logic                  out_stall,
  output erttm_pkg::erttm_out_t out_data
);
  import erttm_pkg::*;

  logic         s1_valid;
  logic         s1_take;
  erttm_pulse_t s1_data;

  // Stage 1: echo edge pairing, overflow counting, pulse length in ticks
  erttm_capture u_capture (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .s1_valid (s1_valid),
    .s1_data  (s1_data),
    .s1_take  (s1_take)
  );

  // Stage 2: ticks to cm, tone top (continuous or banded), duty, mode toggle
  erttm_map u_map (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .s1_data   (s1_data),
    .s1_take   (s1_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
